// ----- rtl/hpt_pkg.sv -----
// ----------------------------------------------------------------------------
// hpt_pkg: shared types and constants of the homogeneous point transform
// Fixed widths, register indexes and the lane control bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package hpt_pkg;

    localparam int NUM_ROWS  = 4;
    localparam int COEF_W    = 16;
    localparam int ROW_W     = 64;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_MATRIX_ROW0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MATRIX_ROW1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MATRIX_ROW2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MATRIX_ROW3 = 3'd3;

    typedef struct packed {
        logic load_prod;
        logic load_sum;
    } hpt_ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/homogeneous_point_transform_4x4.sv -----
// ----------------------------------------------------------------------------
// homogeneous_point_transform_4x4: 4x4 fixed-point matrix times a point
// Four row lanes compute the dot products in parallel; a merge stage
// registers the result and the combined saturation flag.
//
//   Channel  Direction  Contents
//   s_       in         tdata: x, y, z, w (signed Q16.16 each)
//   m_       out        tdata: x, y, z, w; tuser: saturated
//   cfg_     in         write of matrix_row0..3 (four Q4.12 elements each)
//
// One transaction per cycle is accepted while s_tready is high; each
// result passes through the product stage, the sum stage and the output
// register. A stalled output holds only the stages that are full; empty
// stages keep taking input. Reset loads the identity matrix and empties
// the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module homogeneous_point_transform_4x4 #(
    parameter  int COORD_WIDTH    = 32,
    parameter  int COEF_FRAC_BITS = 12,
    localparam int TDATA_W        = ((4 * COORD_WIDTH + 7) / 8) * 8
) (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              s_tvalid,
    output logic                             s_tready,
    input  wire  [TDATA_W-1:0]               s_tdata,  // x, y, z, w
    output logic                             m_tvalid,
    input  wire                              m_tready,
    output logic [TDATA_W-1:0]               m_tdata,  // x, y, z, w
    output logic [0:0]                       m_tuser,  // saturated
    input  wire                              cfg_wr_en,
    input  wire  [hpt_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire  [hpt_pkg::ROW_W-1:0]        cfg_wdata
);

    localparam int PT_W = hpt_pkg::NUM_ROWS * COORD_WIDTH;

    logic [hpt_pkg::ROW_W-1:0] row_reg [hpt_pkg::NUM_ROWS];
    logic                      v1_reg;
    logic                      v1_next;
    logic                      v2_reg;
    logic                      v2_next;
    logic                      ready1;
    logic                      ready2;
    logic                      out_ready;
    hpt_pkg::hpt_ctrl_t        ctrl;
    logic [PT_W-1:0]           point;
    logic [PT_W-1:0]           lane_result;
    logic [hpt_pkg::NUM_ROWS-1:0] lane_sat;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < hpt_pkg::NUM_ROWS; i++) begin
                row_reg[i] <= (hpt_pkg::ROW_W'(1) << COEF_FRAC_BITS) << (hpt_pkg::COEF_W * i);
            end
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                hpt_pkg::REG_MATRIX_ROW0: row_reg[0] <= cfg_wdata;
                hpt_pkg::REG_MATRIX_ROW1: row_reg[1] <= cfg_wdata;
                hpt_pkg::REG_MATRIX_ROW2: row_reg[2] <= cfg_wdata;
                hpt_pkg::REG_MATRIX_ROW3: row_reg[3] <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign ready2         = !v2_reg || out_ready;
    assign ready1         = !v1_reg || ready2;
    assign s_tready       = ready1;
    assign ctrl.load_prod = s_tvalid && ready1;
    assign ctrl.load_sum  = v1_reg && ready2;
    assign v1_next        = ctrl.load_prod || (v1_reg && !ready2);
    assign v2_next        = ctrl.load_sum || (v2_reg && !out_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
        end
    end

    assign point = s_tdata[PT_W-1:0];

    for (genvar r = 0; r < hpt_pkg::NUM_ROWS; r++) begin : g_lane
        hpt_lane #(
            .COORD_WIDTH    (COORD_WIDTH),
            .COEF_FRAC_BITS (COEF_FRAC_BITS)
        ) u_lane (
            .aclk   (aclk),
            .ctrl   (ctrl),
            .row    (row_reg[r]),
            .point  (point),
            .result (lane_result[COORD_WIDTH*r +: COORD_WIDTH]),
            .sat    (lane_sat[r])
        );
    end

    hpt_merge #(
        .COORD_WIDTH (COORD_WIDTH),
        .TDATA_W     (TDATA_W)
    ) u_merge (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (v2_reg),
        .in_ready    (out_ready),
        .lane_result (lane_result),
        .lane_sat    (lane_sat),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

`ifndef SYNTHESIS
    a_full_when_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (v1_reg && v2_reg && m_tvalid))
        else $error("input stalled while the pipeline has room");

    a_out_from_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(v2_reg))
        else $error("result appeared without a summed item");

    a_sum_from_prod: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(v2_reg) |-> $past(v1_reg))
        else $error("sum stage filled without a product item");
`endif

endmodule

`default_nettype wire

// ----- rtl/hpt_lane.sv -----
// ----------------------------------------------------------------------------
// hpt_lane: one matrix row times the point
// Four products in the first stage, rounded sum in the second, then
// saturation to the coordinate width on the way out.
// ----------------------------------------------------------------------------
`default_nettype none

module hpt_lane #(
    parameter int COORD_WIDTH    = 32,
    parameter int COEF_FRAC_BITS = 12
) (
    input  wire                                  aclk,
    input  wire hpt_pkg::hpt_ctrl_t              ctrl,
    input  wire  [hpt_pkg::ROW_W-1:0]            row,
    input  wire  [hpt_pkg::NUM_ROWS*COORD_WIDTH-1:0] point,
    output logic [COORD_WIDTH-1:0]               result,
    output logic                                 sat
);

    localparam int PROD_W = COORD_WIDTH + hpt_pkg::COEF_W;
    localparam int SUM_W  = PROD_W + 2;
    localparam int SHR_W  = SUM_W - COEF_FRAC_BITS;
    localparam logic signed [SUM_W-1:0] RND = SUM_W'(1) << (COEF_FRAC_BITS - 1);
    localparam logic [COORD_WIDTH-1:0] MAX_VAL = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic [COORD_WIDTH-1:0] MIN_VAL = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    logic signed [PROD_W-1:0] prod_next [hpt_pkg::NUM_ROWS];
    logic signed [PROD_W-1:0] prod_reg  [hpt_pkg::NUM_ROWS];
    logic signed [SUM_W-1:0]  sum_next;
    logic signed [SUM_W-1:0]  sum_reg;
    logic signed [SHR_W-1:0]  shr;
    logic [SHR_W-COORD_WIDTH:0] hi_bits;
    logic                     in_range;

    for (genvar j = 0; j < hpt_pkg::NUM_ROWS; j++) begin : g_mul
        logic signed [hpt_pkg::COEF_W-1:0] coef;
        logic signed [COORD_WIDTH-1:0]     coord;
        assign coef  = row[hpt_pkg::COEF_W*j +: hpt_pkg::COEF_W];
        assign coord = point[COORD_WIDTH*j +: COORD_WIDTH];
        assign prod_next[j] = PROD_W'(coef) * PROD_W'(coord);
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load_prod) begin
            prod_reg <= prod_next;
        end
        if (ctrl.load_sum) begin
            sum_reg <= sum_next;
        end
    end

    assign sum_next = SUM_W'(prod_reg[0]) + SUM_W'(prod_reg[1])
                    + SUM_W'(prod_reg[2]) + SUM_W'(prod_reg[3]) + RND;

    assign shr      = SHR_W'(sum_reg >>> COEF_FRAC_BITS);
    assign hi_bits  = shr[SHR_W-1:COORD_WIDTH-1];
    assign in_range = (&hi_bits) || !(|hi_bits);

    always_comb begin
        if (in_range) begin
            result = shr[COORD_WIDTH-1:0];
        end else if (shr[SHR_W-1]) begin
            result = MIN_VAL;
        end else begin
            result = MAX_VAL;
        end
    end

    assign sat = !in_range;

endmodule

`default_nettype wire

// ----- rtl/hpt_merge.sv -----
// ----------------------------------------------------------------------------
// hpt_merge: output register of the transform
// Gathers the four lane results, combines their saturation flags and
// holds the result transaction until the consumer takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module hpt_merge #(
    parameter int COORD_WIDTH = 32,
    parameter int TDATA_W     = 128
) (
    input  wire                                       aclk,
    input  wire                                       aresetn,
    input  wire                                       in_valid,
    output logic                                      in_ready,
    input  wire  [hpt_pkg::NUM_ROWS*COORD_WIDTH-1:0]  lane_result,
    input  wire  [hpt_pkg::NUM_ROWS-1:0]              lane_sat,
    output logic                                      m_tvalid,
    input  wire                                       m_tready,
    output logic [TDATA_W-1:0]                        m_tdata,
    output logic [0:0]                                m_tuser
);

    logic               valid_reg;
    logic               valid_next;
    logic [TDATA_W-1:0] data_reg;
    logic               sat_reg;
    logic               load;

    assign in_ready   = !valid_reg || m_tready;
    assign load       = in_valid && in_ready;
    assign valid_next = load || (valid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= TDATA_W'(lane_result);
            sat_reg  <= |lane_sat;
        end
    end

    assign m_tvalid   = valid_reg;
    assign m_tdata    = data_reg;
    assign m_tuser[0] = sat_reg;

endmodule

`default_nettype wire
